### rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, codes and constants for the four-channel cascade timer.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int unsigned NUM_CH   = 4;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CTRL_W   = 8;
    localparam int unsigned PHASE_W  = 10;

    localparam logic [CTRL_W-1:0] CTRL_KEEP = 8'hC7;
    localparam int unsigned CTRL_CNT_UP_BIT = 2;
    localparam int unsigned CTRL_IRQ_BIT    = 6;
    localparam int unsigned CTRL_START_BIT  = 7;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_WR_RELOAD = 3'd1,
        CMD_WR_CTRL   = 3'd2,
        CMD_RD_COUNT  = 3'd3,
        CMD_RD_CTRL   = 3'd4
    } t_cmd;

    // Bus beat as broadcast to every cell, already qualified by the accept.
    typedef struct packed {
        logic             tick;
        logic             wr_reload;
        logic             wr_ctrl;
        logic [CNT_W-1:0] data;
    } t_bus;

    // Prescaler phase mask for divide by 1, 64, 256, 1024.
    function automatic logic [PHASE_W-1:0] phase_mask(input logic [1:0] sel);
        logic [PHASE_W-1:0] m;
        begin
            case (sel)
                2'd0:    m = 10'h000;
                2'd1:    m = 10'h03F;
                2'd2:    m = 10'h0FF;
                default: m = 10'h3FF;
            endcase
            return m;
        end
    endfunction

endpackage

### rtl/fct_cell.sv
// ----------------------------------------------------------------------------
// fct_cell
// One timer channel: counter, reload, control and prescaler phase.
// ----------------------------------------------------------------------------
module fct_cell
    import fct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bus              i_bus,
    input  logic              i_sel,
    input  logic              i_first,
    input  logic              i_carry,
    output logic              o_carry,
    output logic              o_irq,
    output logic [CNT_W-1:0]  o_count,
    output logic [CTRL_W-1:0] o_ctrl
);

    logic [CNT_W-1:0]   r_count,  n_count;
    logic [CNT_W-1:0]   r_reload, n_reload;
    logic [CTRL_W-1:0]  r_ctrl,   n_ctrl;
    logic [PHASE_W-1:0] r_phase,  n_phase;

    logic               w_started;
    logic               w_cnt_up;
    logic [PHASE_W-1:0] w_phase_inc;
    logic               w_inc;
    logic               w_ovf;

    assign w_started   = r_ctrl[CTRL_START_BIT];
    // channel 0 has no upstream neighbor, so it always runs free
    assign w_cnt_up    = r_ctrl[CTRL_CNT_UP_BIT] & ~i_first;
    assign w_phase_inc = (r_phase + PHASE_W'(1)) & phase_mask(r_ctrl[1:0]);
    assign w_inc       = i_bus.tick & w_started &
                         (w_cnt_up ? i_carry : (w_phase_inc == '0));
    assign w_ovf       = w_inc & (r_count == {CNT_W{1'b1}});

    assign o_carry = w_ovf;
    assign o_irq   = w_ovf & r_ctrl[CTRL_IRQ_BIT];
    assign o_count = r_count;
    assign o_ctrl  = r_ctrl;

    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_ctrl   = r_ctrl;
        n_phase  = r_phase;
        if (i_bus.tick) begin
            if (w_started && !w_cnt_up) begin
                n_phase = w_phase_inc;
            end
            if (w_ovf) begin
                n_count = r_reload;
            end else if (w_inc) begin
                n_count = r_count + CNT_W'(1);
            end
        end
        if (i_bus.wr_reload && i_sel) begin
            n_reload = i_bus.data;
        end
        if (i_bus.wr_ctrl && i_sel) begin
            n_ctrl  = i_bus.data[CTRL_W-1:0] & CTRL_KEEP;
            n_phase = '0;
            if (i_bus.data[CTRL_START_BIT] && !w_started) begin
                n_count = r_reload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_ctrl   <= '0;
            r_phase  <= '0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_ctrl   <= n_ctrl;
            r_phase  <= n_phase;
        end
    end

endmodule

### rtl/four_channel_cascade_timer.sv
// ----------------------------------------------------------------------------
// four_channel_cascade_timer
// Four cascadable 16-bit up-counting timers behind a small register bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one beat per tick or bus access:
//   i_command selects tick, reload write, control write, counter read or
//   control read; i_channel picks the timer for accesses; i_write_data holds
//   write data.
//   Output channel (o_valid / i_ready) returns exactly one beat per input beat:
//   o_read_data holds the read value (zero for non-reads) and o_irq_pulses has
//   one bit per channel that overflowed with irq enabled during a tick.
//   The result is registered: it appears in the output register on the
//   clock after the input beat is taken. Throughput is one beat per cycle
//   when not stalled; o_ready is high whenever the output register is empty
//   or being drained, so a new beat is taken while the previous result is
//   handed over. When the receiver stalls with a result held, o_ready drops
//   and the block holds all timer state until the result is taken (ticks are
//   not lost, they simply wait upstream).
//   The four timer cells sit in a row; an overflow ripples from one cell to
//   the next within the same cycle, so a full cascade resolves in one tick.
//   Reset (i_rst_n low, synchronous) clears all counters, reload values,
//   control bits, prescaler phases and the output valid flag.
// ----------------------------------------------------------------------------
module four_channel_cascade_timer
    import fct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_command,
    input  logic [1:0]        i_channel,
    input  logic [CNT_W-1:0]  i_write_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CNT_W-1:0]  o_read_data,
    output logic [NUM_CH-1:0] o_irq_pulses
);

    logic                  r_valid;
    logic [CNT_W-1:0]      r_read_data,  n_read_data;
    logic [NUM_CH-1:0]     r_irq_pulses;

    logic                  w_fire;
    t_bus                  w_bus;
    logic [NUM_CH:0]       w_carry;
    logic [NUM_CH-1:0]     w_irq;
    logic [CNT_W-1:0]      w_count [NUM_CH];
    logic [CTRL_W-1:0]     w_ctrl  [NUM_CH];

    // Output register drains or is empty: take the next beat.
    assign o_ready = ~r_valid | i_ready;
    assign w_fire  = i_valid & o_ready;

    assign w_bus.tick      = w_fire & (i_command == CMD_TICK);
    assign w_bus.wr_reload = w_fire & (i_command == CMD_WR_RELOAD);
    assign w_bus.wr_ctrl   = w_fire & (i_command == CMD_WR_CTRL);
    assign w_bus.data      = i_write_data;

    // No cascade into the first channel.
    assign w_carry[0] = 1'b0;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_cell
        fct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus),
            .i_sel   (i_channel == 2'(k)),
            .i_first (k == 0),
            .i_carry (w_carry[k]),
            .o_carry (w_carry[k+1]),
            .o_irq   (w_irq[k]),
            .o_count (w_count[k]),
            .o_ctrl  (w_ctrl[k])
        );
    end

    // Reads see state before this beat's update.
    always_comb begin
        case (i_command)
            CMD_RD_COUNT: n_read_data = w_count[i_channel];
            CMD_RD_CTRL:  n_read_data = {{(CNT_W-CTRL_W){1'b0}}, w_ctrl[i_channel]};
            default:      n_read_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_data  <= n_read_data;
            r_irq_pulses <= w_bus.tick ? w_irq : '0;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_data  = r_read_data;
    assign o_irq_pulses = r_irq_pulses;

    // irq bits come only from ticks, read data only from reads
    a_irq_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_command != CMD_TICK) |=> (o_irq_pulses == '0))
        else $error("irq pulse on a non-tick beat");

    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_irq_pulses != '0) |-> (o_read_data == '0))
        else $error("irq pulse together with read data");

    a_ctrl_read_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_command == CMD_RD_CTRL) |=>
        (o_read_data[5:3] == 3'd0 && o_read_data[CNT_W-1:CTRL_W] == '0))
        else $error("control read shows unkept bits");

    a_beat_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_valid)
        else $error("accepted beat produced no result");

endmodule
